// File: design/ppr_pkg.sv
`default_nettype none

package ppr_pkg;

  localparam int LINE_DEPTH_DEF = 128;
  localparam int LEVEL_W        = 5;
  localparam int LEVEL_MAX      = 31;
  localparam int RAMP_W         = 16;
  localparam int RAMP_MAX       = (1 << 16) - 1;
  localparam int RAMP_BASE      = 128;
  localparam int RAMP_SHIFT     = 10;
  localparam int RAMP_TOP       = 127;
  localparam int TIMER_W        = 8;
  localparam int TIMER_MAX      = 255;
  localparam int FADE_W         = 6;
  localparam int FADE_LIMIT     = 32;
  localparam int ALPHA_W        = 5;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 8;
  localparam int ATTACK_W       = 5;
  localparam int DECAY_W        = 5;
  localparam int PAIR_IDX_W     = 6;
  localparam int COLOR_W        = 15;
  localparam int IN_DATA_W      = 8;
  localparam int OUT_DATA_W     = 48;
  localparam int RAMP_IDX_W     = 9;

  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ATTACK_STEP  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY_STEP   = 2'd2;

  typedef struct packed {
    logic                  en;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic wr;   // push new level at head
    logic rd;   // read one entry (registered)
  } line_ctl_t;

  // Brightness weight for entry k (0 = newest); zero past entry 127.
  function automatic logic [RAMP_W-1:0] ramp_weight(input logic [RAMP_IDX_W-1:0] k);
    logic [17:0] v;
    v = 18'(RAMP_BASE) + (18'(7'(RAMP_TOP) - k[6:0]) << RAMP_SHIFT);
    if (k[RAMP_IDX_W-1:7] != '0) begin
      return '0;
    end else if (v > 18'(RAMP_MAX)) begin
      return RAMP_W'(RAMP_MAX);
    end else begin
      return v[RAMP_W-1:0];
    end
  endfunction

  function automatic logic [COLOR_W-1:0] grey(input logic [LEVEL_W-1:0] c);
    return {c, c, c};
  endfunction

endpackage

`default_nettype wire

// File: design/ppr_env.sv
`default_nettype none

module ppr_env (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire ppr_pkg::cfg_wr_t                 cfg,
  input  wire logic                             step,
  input  wire logic                             beat,
  input  wire logic                             fade_en,
  output logic        [ppr_pkg::LEVEL_W-1:0]    level_nxt,
  output logic        [ppr_pkg::ALPHA_W-1:0]    alpha
);

  logic [ppr_pkg::TIMER_W-1:0]    rise_time_r;
  logic [ppr_pkg::ATTACK_W-1:0]   attack_r;
  logic [ppr_pkg::DECAY_W-1:0]    decay_r;
  logic [ppr_pkg::LEVEL_W-1:0]    level_r;
  logic [ppr_pkg::TIMER_W-1:0]    timer_r, timer_nxt;
  logic [ppr_pkg::FADE_W-1:0]     fade_r, fade_nxt;
  logic [ppr_pkg::ALPHA_W-1:0]    alpha_r;
  logic signed [7:0]              sum;

  always_comb begin
    if (timer_r < rise_time_r) begin
      sum = $signed({3'b0, level_r}) + $signed({3'b0, attack_r});
    end else begin
      sum = $signed({3'b0, level_r}) - $signed({3'b0, decay_r});
    end
    if (sum < 0) begin
      level_nxt = '0;
    end else if (sum > 8'sd31) begin
      level_nxt = ppr_pkg::LEVEL_W'(ppr_pkg::LEVEL_MAX);
    end else begin
      level_nxt = sum[ppr_pkg::LEVEL_W-1:0];
    end

    if (beat) begin
      timer_nxt = '0;
    end else if (timer_r < ppr_pkg::TIMER_W'(ppr_pkg::TIMER_MAX)) begin
      timer_nxt = timer_r + 1'b1;
    end else begin
      timer_nxt = timer_r;
    end

    if (fade_en && (fade_r < ppr_pkg::FADE_W'(ppr_pkg::FADE_LIMIT))) begin
      fade_nxt = fade_r + 1'b1;
    end else begin
      fade_nxt = fade_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rise_time_r <= 8'd8;
      attack_r    <= 5'd4;
      decay_r     <= 5'd1;
      level_r     <= '0;
      timer_r     <= '0;
      fade_r      <= '0;
      alpha_r     <= '0;
    end else begin
      if (cfg.en) begin
        case (cfg.index)
          ppr_pkg::CFG_PULSE_LENGTH: rise_time_r <= cfg.data;
          ppr_pkg::CFG_ATTACK_STEP:  attack_r    <= cfg.data[ppr_pkg::ATTACK_W-1:0];
          ppr_pkg::CFG_DECAY_STEP:   decay_r     <= cfg.data[ppr_pkg::DECAY_W-1:0];
          default: ;
        endcase
      end
      if (step) begin
        level_r <= level_nxt;
        timer_r <= timer_nxt;
        fade_r  <= fade_nxt;
        // alpha is taken before this tick's increment
        alpha_r <= fade_r[ppr_pkg::FADE_W-1:1];
      end
    end
  end

  assign alpha = alpha_r;

endmodule

`default_nettype wire

// File: design/ppr_line.sv
`default_nettype none

module ppr_line #(
  parameter  int DEPTH = ppr_pkg::LINE_DEPTH_DEF,
  localparam int KW    = $clog2(2 * ((DEPTH + 1) / 2))
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire ppr_pkg::line_ctl_t            ctl,
  input  wire logic [ppr_pkg::LEVEL_W-1:0]   wr_level,
  input  wire logic [KW-1:0]                 rd_k,
  output logic      [ppr_pkg::LEVEL_W-1:0]   rd_level
);

  localparam int AW = $clog2(DEPTH);
  localparam int FW = $clog2(DEPTH + 1);
  localparam int SW = KW + 1;

  // Only greys are ever pushed, so one level per entry holds the whole color.
  logic [ppr_pkg::LEVEL_W-1:0] mem [DEPTH];
  logic [ppr_pkg::LEVEL_W-1:0] mem_q_r;
  logic                        hit_r;
  logic [AW-1:0]               head_r, head_dec, rd_addr;
  logic [FW-1:0]               fill_r;
  logic [SW-1:0]               sum, wrapped;
  logic                        hit;

  always_comb begin
    head_dec = (head_r == '0) ? AW'(DEPTH - 1) : head_r - 1'b1;
    sum      = SW'(head_r) + SW'(rd_k);
    wrapped  = (sum >= SW'(DEPTH)) ? sum - SW'(DEPTH) : sum;
    rd_addr  = wrapped[AW-1:0];
    // entries never written read as black
    hit      = SW'(rd_k) < SW'(fill_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      fill_r <= '0;
    end else if (ctl.wr) begin
      head_r <= head_dec;
      if (fill_r != FW'(DEPTH)) begin
        fill_r <= fill_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      mem[head_dec] <= wr_level;
    end
    if (ctl.rd) begin
      mem_q_r <= mem[rd_addr];
      hit_r   <= hit;
    end
  end

  assign rd_level = hit_r ? mem_q_r : '0;

endmodule

`default_nettype wire

// File: design/ppr_scale.sv
`default_nettype none

module ppr_scale (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic [ppr_pkg::LEVEL_W-1:0]   level,
  input  wire logic [ppr_pkg::RAMP_W-1:0]    weight,
  output logic      [ppr_pkg::LEVEL_W-1:0]   chan
);

  localparam int PW = ppr_pkg::LEVEL_W + ppr_pkg::RAMP_W;

  logic [PW-1:0]               prod;
  logic [ppr_pkg::LEVEL_W-1:0] chan_r;

  assign prod = PW'(level) * PW'(weight);

  always_ff @(posedge clk) begin
    if (en) begin
      chan_r <= prod[PW-1:ppr_pkg::RAMP_W];
    end
  end

  assign chan = chan_r;

endmodule

`default_nettype wire

// File: design/palette_pulse_ring_modulator.sv
// Channel | Dir | Handshake          | Payload
// in_     | in  | in_tvalid/tready   | in_tdata: beat_changed, fadein_enable
// out_    | out | out_tvalid/tready  | out_tdata: pair, colors, alpha; out_tlast
// cfg_    | in  | cfg_wr_en          | cfg_index, cfg_wdata
//
// A tick reads LINE_DEPTH (rounded up to even) entries; one multiplier scales
// one entry per cycle unless out_tready stalls, emitting a pair per odd entry.
// in_tready is low from the accepting edge until the entry pipeline drains.
// A stalled out_tready freezes the read, multiply and output stages in place.
// Reset (rst_n low, synchronous) clears the line fill count, pointers,
// envelope, timer, fade count and registers to their defaults; no sweep.
`default_nettype none

module palette_pulse_ring_modulator #(
  parameter int LINE_DEPTH = ppr_pkg::LINE_DEPTH_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // [0] beat_changed, [1] fadein_enable, [7:2] zero
  input  wire logic [ppr_pkg::IN_DATA_W-1:0]      in_tdata,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // [5:0] pair_index, [20:6] color_even, [35:21] color_odd,
  // [40:36] blend_alpha, [47:41] zero
  output logic      [ppr_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic                                    out_tlast,
  input  wire logic                               cfg_wr_en,
  input  wire logic [ppr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [ppr_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int PAIRS = (LINE_DEPTH + 1) / 2;
  localparam int NE    = 2 * PAIRS;
  localparam int KW    = $clog2(NE);
  localparam int PXW   = KW + ppr_pkg::PAIR_IDX_W;

  typedef enum logic {ST_IDLE, ST_RUN} state_t;

  state_t                          state_r;
  logic [KW-1:0]                   k_r, s1_k_r, s2_k_r, s2_pk;
  logic                            s1_valid_r, s2_valid_r;
  logic [ppr_pkg::LEVEL_W-1:0]     even_r;
  logic                            out_valid_r, out_last_r;
  logic [ppr_pkg::PAIR_IDX_W-1:0]  out_pair_r;
  logic [ppr_pkg::COLOR_W-1:0]     out_even_r, out_odd_r;
  logic [ppr_pkg::ALPHA_W-1:0]     out_alpha_r;
  logic [PXW-1:0]                  pair_ext;

  logic                            accept, adv, issue, emit;
  ppr_pkg::cfg_wr_t                cfg;
  ppr_pkg::line_ctl_t              line_ctl;
  logic [ppr_pkg::LEVEL_W-1:0]     level_nxt, rd_level, chan;
  logic [ppr_pkg::ALPHA_W-1:0]     alpha;
  logic [ppr_pkg::RAMP_W-1:0]      weight;

  assign in_tready = (state_r == ST_IDLE) && !s1_valid_r && !s2_valid_r;
  assign accept    = in_tvalid && in_tready;
  assign adv       = !out_valid_r || out_tready;
  assign issue     = (state_r == ST_RUN) && adv;
  assign emit      = adv && s2_valid_r && s2_k_r[0];

  assign cfg.en      = cfg_wr_en;
  assign cfg.index   = cfg_index;
  assign cfg.data    = cfg_wdata;
  assign line_ctl.wr = accept;
  assign line_ctl.rd = issue;

  assign weight   = ppr_pkg::ramp_weight(ppr_pkg::RAMP_IDX_W'(s1_k_r));
  assign s2_pk    = s2_k_r >> 1;
  assign pair_ext = PXW'(s2_pk);

  ppr_env u_env (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .step      (accept),
    .beat      (in_tdata[0]),
    .fade_en   (in_tdata[1]),
    .level_nxt (level_nxt),
    .alpha     (alpha)
  );

  ppr_line #(.DEPTH(LINE_DEPTH)) u_line (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (line_ctl),
    .wr_level (level_nxt),
    .rd_k     (k_r),
    .rd_level (rd_level)
  );

  ppr_scale u_scale (
    .clk    (clk),
    .en     (adv && s1_valid_r),
    .level  (rd_level),
    .weight (weight),
    .chan   (chan)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      k_r         <= '0;
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            state_r <= ST_RUN;
            k_r     <= '0;
          end
        end
        ST_RUN: begin
          if (issue) begin
            k_r <= k_r + 1'b1;
            if (k_r == KW'(NE - 1)) begin
              state_r <= ST_IDLE;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
      if (adv) begin
        s1_valid_r <= issue;
        s2_valid_r <= s1_valid_r;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_k_r <= k_r;
    end
    if (adv) begin
      s2_k_r <= s1_k_r;
      if (s2_valid_r && !s2_k_r[0]) begin
        even_r <= chan;
      end
    end
    if (emit) begin
      out_pair_r  <= pair_ext[ppr_pkg::PAIR_IDX_W-1:0];
      out_even_r  <= ppr_pkg::grey(even_r);
      out_odd_r   <= ppr_pkg::grey(chan);
      out_alpha_r <= alpha;
      out_last_r  <= (s2_k_r == KW'(NE - 1));
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {7'b0, out_alpha_r, out_odd_r, out_even_r, out_pair_r};

  a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_tready)
    else $error("input taken again right after a request");

  a_last_pair_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |->
      (out_tdata[5:0] == ppr_pkg::PAIR_IDX_W'(PAIRS - 1)))
    else $error("last pair carries wrong index");

  a_out_from_odd_entry: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s2_valid_r && s2_k_r[0]))
    else $error("result raised without an odd entry leaving the multiplier");

endmodule

`default_nettype wire
